// ===== hw/rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared constants, entry and memory request types, and the action, status,
// comparator select and sequencer state codes.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = $clog2(2 * CAPACITY + 1);
  localparam int SYM_W    = 8;
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr_a;
    idx_t   raddr_b;
  } ram_req_t;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_CLEAR   = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMP_UP   = 2'd0,
    CMP_PICK = 2'd1,
    CMP_DOWN = 2'd2
  } cmp_sel_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_UP      = 3'd1,
    S_UP_CMP  = 3'd2,
    S_EX_LOAD = 3'd3,
    S_DN      = 3'd4,
    S_DN_SEL  = 3'd5,
    S_DN_CMP  = 3'd6,
    S_FIN     = 3'd7
  } state_e;

endpackage

// ===== hw/rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// Heap entry memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module mhpq_ram (
  input  logic               clk_i,
  input  mhpq_pkg::ram_req_t req_i,
  output mhpq_pkg::entry_t   rdata_a_o,
  output mhpq_pkg::entry_t   rdata_b_o
);

  mhpq_pkg::entry_t mem_q [mhpq_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[req_i.raddr_a];
    rdata_b_o <= mem_q[req_i.raddr_b];
  end

endmodule

// ===== hw/rtl/mhpq_cmp.sv =====
// ----------------------------------------------------------------------------
// Shared key comparator
// Selects one pair of keys for the current sequencer step and reports
// whether the first key is strictly smaller than the second.
// ----------------------------------------------------------------------------
module mhpq_cmp (
  input  mhpq_pkg::cmp_sel_e         sel_i,
  input  logic [mhpq_pkg::KEY_W-1:0] mov_key_i,
  input  logic [mhpq_pkg::KEY_W-1:0] rd_a_key_i,
  input  logic [mhpq_pkg::KEY_W-1:0] rd_b_key_i,
  input  logic [mhpq_pkg::KEY_W-1:0] child_key_i,
  output logic                       lt_o
);

  logic [mhpq_pkg::KEY_W-1:0] op_a;
  logic [mhpq_pkg::KEY_W-1:0] op_b;

  always_comb begin
    unique case (sel_i)
      mhpq_pkg::CMP_UP: begin
        op_a = mov_key_i;
        op_b = rd_a_key_i;
      end
      mhpq_pkg::CMP_PICK: begin
        op_a = rd_b_key_i;
        op_b = rd_a_key_i;
      end
      mhpq_pkg::CMP_DOWN: begin
        op_a = child_key_i;
        op_b = mov_key_i;
      end
      default: begin
        op_a = mov_key_i;
        op_b = rd_a_key_i;
      end
    endcase
  end

  assign lt_o = (op_a < op_b);

endmodule

// ===== hw/rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heap sequencer
// Runs insert with sift-up and extract with sift-down one level at a time,
// holding the moving entry in a register and writing only the hole.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic [mhpq_pkg::SYM_W-1:0]         symbol_i,
  input  logic [mhpq_pkg::KEY_W-1:0]         weight_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [mhpq_pkg::SYM_W-1:0]         out_symbol_o,
  output logic [mhpq_pkg::KEY_W-1:0]         out_weight_o,
  output logic                               out_valid_o,
  output logic [1:0]                         status_o,
  output logic [mhpq_pkg::OCC_W-1:0]         occupancy_o,
  output mhpq_pkg::ram_req_t                 ram_req_o,
  input  mhpq_pkg::entry_t                   rd_a_i,
  input  mhpq_pkg::entry_t                   rd_b_i,
  output mhpq_pkg::cmp_sel_e                 cmp_sel_o,
  output logic [mhpq_pkg::KEY_W-1:0]         mov_key_o,
  output logic [mhpq_pkg::KEY_W-1:0]         child_key_o,
  input  logic                               cmp_lt_i
);

  localparam int CHW = mhpq_pkg::CHILD_W;

  mhpq_pkg::state_e  state_q, state_d;
  mhpq_pkg::cnt_t    count_q, count_d;
  mhpq_pkg::idx_t    hole_q, hole_d;
  mhpq_pkg::idx_t    child_idx_q, child_idx_d;
  mhpq_pkg::entry_t  mov_q, mov_d;
  mhpq_pkg::entry_t  child_q, child_d;
  mhpq_pkg::entry_t  wk_ent_q, wk_ent_d;
  logic              wk_valid_q, wk_valid_d;
  mhpq_pkg::status_e wk_status_q, wk_status_d;

  logic                      res_valid_q, res_valid_d;
  mhpq_pkg::entry_t          out_ent_q, out_ent_d;
  logic                      out_valid_q, out_valid_d;
  mhpq_pkg::status_e         out_status_q, out_status_d;
  logic [mhpq_pkg::OCC_W-1:0] occ_q, occ_d;

  logic           accept;
  logic [CHW-1:0] left;
  logic [CHW-1:0] right;
  logic [CHW-1:0] count_ext;
  mhpq_pkg::idx_t parent;

  assign accept    = in_valid_i && in_ready_o;
  assign left      = (CHW'(hole_q) << 1) + CHW'(1);
  assign right     = left + CHW'(1);
  assign count_ext = CHW'(count_q);
  assign parent    = (hole_q - mhpq_pkg::idx_t'(1)) >> 1;

  assign in_ready_o   = (state_q == mhpq_pkg::S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign out_symbol_o = out_ent_q.sym;
  assign out_weight_o = out_ent_q.key;
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign occupancy_o  = occ_q;
  assign mov_key_o    = mov_q.key;
  assign child_key_o  = child_q.key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhpq_pkg::S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    child_idx_q  <= child_idx_d;
    mov_q        <= mov_d;
    child_q      <= child_d;
    wk_ent_q     <= wk_ent_d;
    wk_valid_q   <= wk_valid_d;
    wk_status_q  <= wk_status_d;
    out_ent_q    <= out_ent_d;
    out_valid_q  <= out_valid_d;
    out_status_q <= out_status_d;
    occ_q        <= occ_d;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    hole_d       = hole_q;
    child_idx_d  = child_idx_q;
    mov_d        = mov_q;
    child_d      = child_q;
    wk_ent_d     = wk_ent_q;
    wk_valid_d   = wk_valid_q;
    wk_status_d  = wk_status_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    out_ent_d    = out_ent_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    occ_d        = occ_q;
    cmp_sel_o    = mhpq_pkg::CMP_UP;

    ram_req_o.we      = 1'b0;
    ram_req_o.waddr   = hole_q;
    ram_req_o.wdata   = mov_q;
    ram_req_o.raddr_a = parent;
    ram_req_o.raddr_b = parent;

    unique case (state_q)
      mhpq_pkg::S_IDLE: begin
        ram_req_o.raddr_a = '0;
        ram_req_o.raddr_b = mhpq_pkg::idx_t'(count_q - mhpq_pkg::cnt_t'(1));
        if (accept) begin
          wk_ent_d    = '0;
          wk_valid_d  = 1'b0;
          wk_status_d = mhpq_pkg::ST_OK;
          state_d     = mhpq_pkg::S_FIN;
          case (mhpq_pkg::act_e'(action_i))
            mhpq_pkg::ACT_INSERT: begin
              if (count_q >= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY)) begin
                wk_status_d = mhpq_pkg::ST_FULL;
              end else begin
                mov_d   = '{sym: symbol_i, key: weight_i};
                hole_d  = mhpq_pkg::idx_t'(count_q);
                count_d = count_q + mhpq_pkg::cnt_t'(1);
                state_d = mhpq_pkg::S_UP;
              end
            end
            mhpq_pkg::ACT_EXTRACT: begin
              if (count_q == '0) begin
                wk_status_d = mhpq_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - mhpq_pkg::cnt_t'(1);
                state_d = mhpq_pkg::S_EX_LOAD;
              end
            end
            mhpq_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      mhpq_pkg::S_UP: begin
        if (hole_q == '0) begin
          ram_req_o.we = 1'b1;
          state_d      = mhpq_pkg::S_FIN;
        end else begin
          state_d = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        cmp_sel_o    = mhpq_pkg::CMP_UP;
        ram_req_o.we = 1'b1;
        if (cmp_lt_i) begin
          ram_req_o.wdata = rd_a_i;
          hole_d          = parent;
          state_d         = mhpq_pkg::S_UP;
        end else begin
          state_d = mhpq_pkg::S_FIN;
        end
      end
      mhpq_pkg::S_EX_LOAD: begin
        wk_ent_d   = rd_a_i;
        wk_valid_d = 1'b1;
        mov_d      = rd_b_i;
        hole_d     = '0;
        state_d    = (count_q == '0) ? mhpq_pkg::S_FIN : mhpq_pkg::S_DN;
      end
      mhpq_pkg::S_DN: begin
        ram_req_o.raddr_a = mhpq_pkg::idx_t'(left);
        ram_req_o.raddr_b = mhpq_pkg::idx_t'(right);
        if (left >= count_ext) begin
          ram_req_o.we = 1'b1;
          state_d      = mhpq_pkg::S_FIN;
        end else begin
          state_d = mhpq_pkg::S_DN_SEL;
        end
      end
      mhpq_pkg::S_DN_SEL: begin
        cmp_sel_o = mhpq_pkg::CMP_PICK;
        if ((right < count_ext) && cmp_lt_i) begin
          child_d     = rd_b_i;
          child_idx_d = mhpq_pkg::idx_t'(right);
        end else begin
          child_d     = rd_a_i;
          child_idx_d = mhpq_pkg::idx_t'(left);
        end
        state_d = mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmp_sel_o    = mhpq_pkg::CMP_DOWN;
        ram_req_o.we = 1'b1;
        if (cmp_lt_i) begin
          ram_req_o.wdata = child_q;
          hole_d          = child_idx_q;
          state_d         = mhpq_pkg::S_DN;
        end else begin
          state_d = mhpq_pkg::S_FIN;
        end
      end
      mhpq_pkg::S_FIN: begin
        if (!res_valid_q || res_ready_i) begin
          res_valid_d  = 1'b1;
          out_ent_d    = wk_ent_q;
          out_valid_d  = wk_valid_q;
          out_status_d = wk_status_q;
          occ_d        = mhpq_pkg::OCC_W'(count_q);
          state_d      = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY))
    else $error("Entry count exceeds capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhpq_pkg::S_UP) |-> (mhpq_pkg::cnt_t'(hole_q) < count_q))
    else $error("Sift-up hole lies outside the heap.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhpq_pkg::S_DN_CMP) |-> (child_idx_q > hole_q))
    else $error("Sift-down child is not below its parent.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == mhpq_pkg::ACT_INSERT) &&
     (count_q < mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY)))
    |=> (count_q == $past(count_q) + mhpq_pkg::cnt_t'(1)))
    else $error("Insert did not grow the heap by one entry.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && out_valid_q) |-> (out_status_q == mhpq_pkg::ST_OK))
    else $error("Extracted item reported with a failure status.");

endmodule

// ===== hw/rtl/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Insert: sift-up climbs one level per step until the entry reaches the root
// or its parent is not larger. Extract: sift-down sinks one level per step
// until it reaches a leaf or no child is smaller. Clear, the unused action
// code and rejected actions go straight to the final step. The next item is accepted as its result
// appears; a result still waiting holds the sequencer in its final step.
// Reset empties the heap at once and leaves the entry memory as it is.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [mhpq_pkg::SYM_W-1:0] symbol_i,
  input  logic [mhpq_pkg::KEY_W-1:0] weight_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [mhpq_pkg::SYM_W-1:0] out_symbol_o,
  output logic [mhpq_pkg::KEY_W-1:0] out_weight_o,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [mhpq_pkg::OCC_W-1:0] occupancy_o
);

  mhpq_pkg::ram_req_t         ram_req;
  mhpq_pkg::entry_t           rd_a;
  mhpq_pkg::entry_t           rd_b;
  mhpq_pkg::cmp_sel_e         cmp_sel;
  logic [mhpq_pkg::KEY_W-1:0] mov_key;
  logic [mhpq_pkg::KEY_W-1:0] child_key;
  logic                       cmp_lt;

  mhpq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .symbol_i     (symbol_i),
    .weight_i     (weight_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_symbol_o (out_symbol_o),
    .out_weight_o (out_weight_o),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o),
    .ram_req_o    (ram_req),
    .rd_a_i       (rd_a),
    .rd_b_i       (rd_b),
    .cmp_sel_o    (cmp_sel),
    .mov_key_o    (mov_key),
    .child_key_o  (child_key),
    .cmp_lt_i     (cmp_lt)
  );

  mhpq_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  mhpq_cmp u_cmp (
    .sel_i       (cmp_sel),
    .mov_key_i   (mov_key),
    .rd_a_key_i  (rd_a.key),
    .rd_b_key_i  (rd_b.key),
    .child_key_i (child_key),
    .lt_o        (cmp_lt)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue testbench
// Drives insert, extract-min, clear and the unused action code into the
// heap, keeps its own copy of the heap to predict every result, and checks
// each result field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [mhpq_pkg::SYM_W-1:0] sym;
    logic [mhpq_pkg::KEY_W-1:0] key;
    logic                       vld;
    logic [1:0]                 st;
    logic [mhpq_pkg::OCC_W-1:0] occ;
  } heap_result_t;

  class heap_tracker;
    logic [mhpq_pkg::KEY_W-1:0] keys [mhpq_pkg::CAPACITY];
    logic [mhpq_pkg::SYM_W-1:0] syms [mhpq_pkg::CAPACITY];
    int                         held;
    int                         fails;
    heap_result_t               pending_results [$];

    function new();
      held  = 0;
      fails = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [mhpq_pkg::KEY_W-1:0] k;
      logic [mhpq_pkg::SYM_W-1:0] s;
      k       = keys[a];
      s       = syms[a];
      keys[a] = keys[b];
      syms[a] = syms[b];
      keys[b] = k;
      syms[b] = s;
    endfunction

    function void note_action(logic [1:0] act, logic [mhpq_pkg::SYM_W-1:0] sym,
                              logic [mhpq_pkg::KEY_W-1:0] wt);
      heap_result_t r;
      int           pos;
      int           best;
      int           lchild;
      r = '0;
      r.st = mhpq_pkg::ST_OK;
      case (act)
        mhpq_pkg::ACT_INSERT: begin
          if (held >= mhpq_pkg::CAPACITY) begin
            r.st = mhpq_pkg::ST_FULL;
          end else begin
            keys[held] = wt;
            syms[held] = sym;
            pos = held;
            held++;
            while (pos > 0) begin
              if (keys[pos] < keys[(pos - 1) / 2]) begin
                swap_slots(pos, (pos - 1) / 2);
                pos = (pos - 1) / 2;
              end else begin
                break;
              end
            end
          end
        end
        mhpq_pkg::ACT_EXTRACT: begin
          if (held == 0) begin
            r.st = mhpq_pkg::ST_EMPTY;
          end else begin
            r.sym = syms[0];
            r.key = keys[0];
            r.vld = 1'b1;
            held--;
            keys[0] = keys[held];
            syms[0] = syms[held];
            pos = 0;
            while (1) begin
              best   = pos;
              lchild = 2 * pos + 1;
              if (lchild < held && keys[lchild] < keys[best]) best = lchild;
              if (lchild + 1 < held && keys[lchild + 1] < keys[best]) best = lchild + 1;
              if (best == pos) break;
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
        mhpq_pkg::ACT_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      r.occ = mhpq_pkg::OCC_W'(held);
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [mhpq_pkg::KEY_W-1:0] want,
                              logic [mhpq_pkg::KEY_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        fails++;
        return;
      end
      want = pending_results.pop_front();
      check_field("out_symbol", mhpq_pkg::KEY_W'(want.sym), mhpq_pkg::KEY_W'(got.sym));
      check_field("out_weight", want.key, got.key);
      check_field("out_valid", mhpq_pkg::KEY_W'(want.vld), mhpq_pkg::KEY_W'(got.vld));
      check_field("status", mhpq_pkg::KEY_W'(want.st), mhpq_pkg::KEY_W'(got.st));
      check_field("occupancy", mhpq_pkg::KEY_W'(want.occ), mhpq_pkg::KEY_W'(got.occ));
    endfunction
  endclass

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 action_i    = 2'd0;
  logic [mhpq_pkg::SYM_W-1:0] symbol_i    = '0;
  logic [mhpq_pkg::KEY_W-1:0] weight_i    = '0;
  logic                       res_valid_o;
  logic                       res_ready_i = 1'b0;
  logic [mhpq_pkg::SYM_W-1:0] out_symbol_o;
  logic [mhpq_pkg::KEY_W-1:0] out_weight_o;
  logic                       out_valid_o;
  logic [1:0]                 status_o;
  logic [mhpq_pkg::OCC_W-1:0] occupancy_o;

  heap_tracker board;
  int          burst_left = 0;
  int          sent_items = 0;
  int          rx_mode    = 0;
  int          rx_tick    = 0;
  int          stall_left = 0;
  logic        rx_ready;

  min_heap_priority_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .symbol_i     (symbol_i),
    .weight_i     (weight_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .out_symbol_o (out_symbol_o),
    .out_weight_o (out_weight_o),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left--;
      rx_ready = 1'b0;
    end else begin
      case (rx_mode)
        0: rx_ready = 1'b1;
        1: rx_ready = ($urandom_range(0, 3) != 0);
        2: rx_ready = ($urandom_range(0, 3) == 0);
        default: begin
          rx_ready = 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 25);
        end
      endcase
    end
    res_ready_i <= rx_ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) begin
      board.check_result('{out_symbol_o, out_weight_o, out_valid_o, status_o,
                           occupancy_o});
    end
  end

  function automatic logic [mhpq_pkg::KEY_W-1:0] rand_weight();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return mhpq_pkg::KEY_W'($urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return mhpq_pkg::KEY_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [1:0] pick_action(int ins_pct, int clr_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < clr_pct) return mhpq_pkg::ACT_CLEAR;
    if (r < clr_pct + 3) return ACT_NOP;
    if (r < clr_pct + 3 + ins_pct) return mhpq_pkg::ACT_INSERT;
    return mhpq_pkg::ACT_EXTRACT;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(logic [1:0] act, logic [mhpq_pkg::SYM_W-1:0] sym,
                           logic [mhpq_pkg::KEY_W-1:0] wt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i   <= act;
    symbol_i   <= sym;
    weight_i   <= wt;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_action(act, sym, wt);
    if (act != ACT_NOP) sent_items++;
    @(negedge clk_i);
  endtask

  task automatic push_random(int ins_pct, int clr_pct);
    push_item(pick_action(ins_pct, clr_pct), 8'($urandom_range(0, 255)), rand_weight());
  endtask

  task automatic fill_heap();
    while (board.held < mhpq_pkg::CAPACITY) push_random(90, 0);
    repeat ($urandom_range(1, 3)) begin
      push_item(mhpq_pkg::ACT_INSERT, 8'($urandom_range(0, 255)), rand_weight());
    end
  endtask

  task automatic drain_heap();
    while (board.held > 0) push_random(10, 0);
    repeat ($urandom_range(1, 2)) begin
      push_item(mhpq_pkg::ACT_EXTRACT, 8'($urandom_range(0, 255)), rand_weight());
    end
  endtask

  initial begin
    int guard;
    int phase_len;
    int ins_pct;
    board = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_item(mhpq_pkg::ACT_EXTRACT, 8'hFF, '1);
    push_item(ACT_NOP, 8'h00, '0);
    push_item(mhpq_pkg::ACT_CLEAR, 8'hFF, '1);
    push_item(mhpq_pkg::ACT_INSERT, 8'hFF, '1);
    push_item(mhpq_pkg::ACT_INSERT, 8'h00, '0);
    push_item(mhpq_pkg::ACT_INSERT, 8'hA5, 32'd5);
    push_item(mhpq_pkg::ACT_INSERT, 8'h5A, 32'd5);
    push_item(mhpq_pkg::ACT_INSERT, 8'h01, 32'd5);
    push_item(mhpq_pkg::ACT_INSERT, 8'h33, 32'd3);
    push_item(ACT_NOP, 8'($urandom_range(0, 255)), $urandom());
    repeat (3) push_item(mhpq_pkg::ACT_EXTRACT, 8'h00, '0);
    push_item(mhpq_pkg::ACT_CLEAR, 8'h00, '0);
    push_item(mhpq_pkg::ACT_EXTRACT, 8'h00, '0);
    push_item(mhpq_pkg::ACT_INSERT, 8'h07, 32'd7);
    push_item(mhpq_pkg::ACT_INSERT, 8'h08, 32'd7);
    push_item(mhpq_pkg::ACT_INSERT, 8'h09, 32'd7);
    repeat (4) push_item(mhpq_pkg::ACT_EXTRACT, 8'h00, '0);

    fill_heap();
    drain_heap();
    while (sent_items < 520) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: ins_pct = 70;
        1: ins_pct = 25;
        default: ins_pct = 47;
      endcase
      repeat (phase_len) push_random(ins_pct, 3);
      if ($urandom_range(0, 5) == 0) fill_heap();
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (board.pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (board.pending_results.size() != 0) begin
      $error("%0d results never arrived", board.pending_results.size());
      board.fails++;
    end
    repeat (40) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/mhpq_cmp.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/min_heap_priority_queue.sv
tb/sv/tb.sv
